@@ design/rrv_pkg.sv @@
`timescale 1ns / 1ps

package rrv_pkg;

    // external formats
    localparam int COMP_W   = 16;
    localparam int FRAC_W   = 14;
    localparam int ETA_W    = 16;
    localparam int ETA_FRAC = 12;

    localparam int HALF = 1 << (FRAC_W - 1);
    localparam int ONE  = 1 << FRAC_W;
    localparam int ONE2 = 1 << (2 * FRAC_W);

    // internal widths
    localparam int MUL_W  = 2 * COMP_W;
    localparam int DOT_W  = 2 * COMP_W + 2;
    localparam int C_W    = FRAC_W + 1;
    localparam int NRM_W  = COMP_W + 1;
    localparam int R_W    = ETA_FRAC + FRAC_W + 1;
    localparam int RR_W   = 2 * R_W;
    localparam int Q_W    = RR_W - FRAC_W;
    localparam int CC_W   = 2 * C_W;
    localparam int S_W    = FRAC_W + 1;
    localparam int RCP_W  = R_W + C_W;
    localparam int RC_W   = RCP_W - FRAC_W;
    localparam int PROD_W = Q_W + S_W;
    localparam int K_W    = 2 * FRAC_W + 1;
    localparam int T_W    = FRAC_W + 1;
    localparam int SQ_IN_W = 2 * T_W;
    localparam int M_W    = RC_W + 1;
    localparam int PIX_W  = R_W + 1 + COMP_W;
    localparam int MN_W   = M_W + NRM_W;
    localparam int SUM_W  = MN_W + 2;

    // iterative units
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (R_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int SQ_STEPS   = 3;
    localparam int SQ_STAGES  = (T_W + SQ_STEPS - 1) / SQ_STEPS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [COMP_W-1:0] inc_x;
        logic signed [COMP_W-1:0] inc_y;
        logic signed [COMP_W-1:0] inc_z;
        logic signed [COMP_W-1:0] normal_x;
        logic signed [COMP_W-1:0] normal_y;
        logic signed [COMP_W-1:0] normal_z;
        logic [ETA_W-1:0]         index_ratio;
    } t_in_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     total_reflect;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic signed [COMP_W-1:0] inc_x;
        logic signed [COMP_W-1:0] inc_y;
        logic signed [COMP_W-1:0] inc_z;
        logic signed [NRM_W-1:0]  nrm_x;
        logic signed [NRM_W-1:0]  nrm_y;
        logic signed [NRM_W-1:0]  nrm_z;
        logic [C_W-1:0]           cos_c;
        logic                     outside;
        logic [ETA_W-1:0]         eta;
    } t_mid_item;

endpackage

@@ design/rrv_front.sv @@
`timescale 1ns / 1ps

module rrv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  rrv_pkg::t_in_item   i_item,
    output logic                o_valid,
    output rrv_pkg::t_mid_item  o_mid,
    input  logic                i_q_full
);
    import rrv_pkg::*;

    localparam logic signed [DOT_W-1:0] DOT_ONE = DOT_W'(ONE2);

    logic                      w_adv;
    t_in_item                  r_s1;
    logic                      r_v1;
    t_in_item                  r_s2;
    logic signed [MUL_W-1:0]   r_px, r_py, r_pz;
    logic                      r_v2;
    t_mid_item                 r_mid, n_mid;
    logic                      r_v3;

    logic signed [DOT_W-1:0]   w_dot, w_dotc, w_absd;
    logic                      w_out;
    logic [2*FRAC_W:0]         w_ad;
    logic [2*FRAC_W+1:0]       w_csum;

    // hold everything while the classified request cannot enter the queue
    assign w_adv  = !r_v3 || !i_q_full;
    assign o_full = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1  <= i_item;
            r_s2  <= r_s1;
            r_px  <= r_s1.inc_x * r_s1.normal_x;
            r_py  <= r_s1.inc_y * r_s1.normal_y;
            r_pz  <= r_s1.inc_z * r_s1.normal_z;
            r_mid <= n_mid;
        end
    end

    always_comb begin
        w_dot = DOT_W'(r_px) + DOT_W'(r_py) + DOT_W'(r_pz);
        w_out = w_dot < 0;
        if (w_dot > DOT_ONE) begin
            w_dotc = DOT_ONE;
        end else if (w_dot < -DOT_ONE) begin
            w_dotc = -DOT_ONE;
        end else begin
            w_dotc = w_dot;
        end
        w_absd = w_out ? -w_dotc : w_dotc;
        w_ad   = w_absd[2*FRAC_W:0];
        w_csum = (2*FRAC_W+2)'(w_ad) + (2*FRAC_W+2)'(HALF);

        n_mid.inc_x   = r_s2.inc_x;
        n_mid.inc_y   = r_s2.inc_y;
        n_mid.inc_z   = r_s2.inc_z;
        // a zero dot product counts as inside: flip the normal
        n_mid.nrm_x   = w_out ? NRM_W'(r_s2.normal_x) : -NRM_W'(r_s2.normal_x);
        n_mid.nrm_y   = w_out ? NRM_W'(r_s2.normal_y) : -NRM_W'(r_s2.normal_y);
        n_mid.nrm_z   = w_out ? NRM_W'(r_s2.normal_z) : -NRM_W'(r_s2.normal_z);
        n_mid.cos_c   = w_csum[FRAC_W+C_W-1:FRAC_W];
        n_mid.outside = w_out;
        n_mid.eta     = (r_s2.index_ratio == '0) ? ETA_W'(1) : r_s2.index_ratio;
    end

    assign o_valid = r_v3;
    assign o_mid   = r_mid;

endmodule

@@ design/rrv_queue.sv @@
`timescale 1ns / 1ps

module rrv_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rrv_pkg::t_mid_item  i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output rrv_pkg::t_mid_item  o_data
);
    import rrv_pkg::*;

    t_mid_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               w_wr, w_rd;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ design/rrv_div.sv @@
`timescale 1ns / 1ps

module rrv_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rrv_pkg::R_W-1:0]   i_num,
    input  logic [rrv_pkg::ETA_W-1:0] i_den,
    output logic [rrv_pkg::R_W-1:0]   o_quo
);
    import rrv_pkg::*;

    logic [ETA_W-1:0] w_rem [DIV_STAGES+1];
    logic [R_W-1:0]   w_num [DIV_STAGES+1];
    logic [R_W-1:0]   w_quo [DIV_STAGES+1];
    logic [ETA_W-1:0] w_den [DIV_STAGES+1];

    assign w_rem[0] = '0;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;

    // restoring division, DIV_STEPS quotient bits per stage
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [ETA_W-1:0] r_rem, n_rem, r_den;
        logic [R_W-1:0]   r_num, n_num, r_quo, n_quo;
        logic [ETA_W:0]   w_trial;

        always_comb begin
            n_rem   = w_rem[g];
            n_num   = w_num[g];
            n_quo   = w_quo[g];
            w_trial = '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (g * DIV_STEPS + j < R_W) begin
                    w_trial = {n_rem, n_num[R_W-1]};
                    n_num   = n_num << 1;
                    if (w_trial >= {1'b0, w_den[g]}) begin
                        w_trial = w_trial - {1'b0, w_den[g]};
                        n_quo   = {n_quo[R_W-2:0], 1'b1};
                    end else begin
                        n_quo   = {n_quo[R_W-2:0], 1'b0};
                    end
                    n_rem = w_trial[ETA_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_num <= n_num;
                r_quo <= n_quo;
                r_den <= w_den[g];
            end
        end

        assign w_rem[g+1] = r_rem;
        assign w_num[g+1] = r_num;
        assign w_quo[g+1] = r_quo;
        assign w_den[g+1] = r_den;
    end

    assign o_quo = w_quo[DIV_STAGES];

endmodule

@@ design/rrv_isqrt.sv @@
`timescale 1ns / 1ps

module rrv_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rrv_pkg::SQ_IN_W-1:0] i_rad,
    output logic [rrv_pkg::T_W-1:0]     o_root
);
    import rrv_pkg::*;

    localparam int REM_W = T_W + 2;

    logic [REM_W-1:0]   w_rem  [SQ_STAGES+1];
    logic [SQ_IN_W-1:0] w_rad  [SQ_STAGES+1];
    logic [T_W-1:0]     w_root [SQ_STAGES+1];

    assign w_rem[0]  = '0;
    assign w_rad[0]  = i_rad;
    assign w_root[0] = '0;

    // digit-by-digit square root, one radicand bit pair per step
    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        logic [REM_W-1:0]   r_rem, n_rem;
        logic [SQ_IN_W-1:0] r_rad, n_rad;
        logic [T_W-1:0]     r_root, n_root;
        logic [REM_W+1:0]   w_acc, w_trial;

        always_comb begin
            n_rem   = w_rem[g];
            n_rad   = w_rad[g];
            n_root  = w_root[g];
            w_acc   = '0;
            w_trial = '0;
            for (int j = 0; j < SQ_STEPS; j++) begin
                if (g * SQ_STEPS + j < T_W) begin
                    w_acc   = {n_rem, n_rad[SQ_IN_W-1 -: 2]};
                    n_rad   = n_rad << 2;
                    w_trial = (REM_W+2)'({n_root, 2'b01});
                    if (w_acc >= w_trial) begin
                        w_acc  = w_acc - w_trial;
                        n_root = {n_root[T_W-2:0], 1'b1};
                    end else begin
                        n_root = {n_root[T_W-2:0], 1'b0};
                    end
                    n_rem = w_acc[REM_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_rad  <= n_rad;
                r_root <= n_root;
            end
        end

        assign w_rem[g+1]  = r_rem;
        assign w_rad[g+1]  = r_rad;
        assign w_root[g+1] = r_root;
    end

    assign o_root = w_root[SQ_STAGES];

endmodule

@@ design/rrv_back.sv @@
`timescale 1ns / 1ps

module rrv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rrv_pkg::t_mid_item  i_mid,
    output logic                o_take,
    output logic                o_empty,
    input  logic                i_pop,
    output rrv_pkg::t_out_item  o_result
);
    import rrv_pkg::*;

    typedef struct packed {
        logic signed [PIX_W-1:0] pix_x;
        logic signed [PIX_W-1:0] pix_y;
        logic signed [PIX_W-1:0] pix_z;
        logic signed [NRM_W-1:0] nrm_x;
        logic signed [NRM_W-1:0] nrm_y;
        logic signed [NRM_W-1:0] nrm_z;
        logic [RC_W-1:0]         rc;
        logic                    tir;
    } t_tail;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COMP_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (COMP_W - 1));

    function automatic logic signed [COMP_W-1:0] f_round_sat(
        input logic signed [PIX_W-1:0] pix,
        input logic signed [MN_W-1:0]  mn
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] sh;
        sum = SUM_W'(pix) + SUM_W'(mn) + SUM_W'(HALF);
        sh  = sum >>> FRAC_W;
        if (sh > SAT_HI) begin
            sh = SAT_HI;
        end else if (sh < SAT_LO) begin
            sh = SAT_LO;
        end
        return COMP_W'(sh);
    endfunction

    logic                    w_adv;
    logic [R_W-1:0]          w_num, w_quo;

    t_mid_item               r_dly [DIV_STAGES];
    logic [DIV_STAGES-1:0]   r_dly_v;
    t_mid_item               w_dly_out;

    logic [R_W-1:0]          r_a_r;
    t_mid_item               r_a_mid;
    logic                    r_a_v;

    logic [RR_W-1:0]         r_b_rr;
    logic [RCP_W-1:0]        r_b_rcp;
    logic [CC_W-1:0]         r_b_cc;
    t_tail                   r_b_tail;
    logic                    r_b_v;

    logic [RR_W-1:0]         w_rrh;
    logic [CC_W-1:0]         w_sh;
    logic [RCP_W-1:0]        w_rch;
    t_tail                   w_c_tail;
    logic [Q_W-1:0]          r_c_q;
    logic [S_W-1:0]          r_c_s;
    t_tail                   r_c_tail;
    logic                    r_c_v;

    logic [PROD_W-1:0]       r_d_prod;
    t_tail                   r_d_tail;
    logic                    r_d_v;

    logic                    w_tir;
    logic [K_W-1:0]          w_k;
    t_tail                   w_sq_in;
    t_tail                   r_sq [SQ_STAGES];
    logic [SQ_STAGES-1:0]    r_sq_v;
    logic [T_W-1:0]          w_root;

    logic signed [M_W-1:0]   r_f_m;
    t_tail                   r_f_tail;
    logic                    r_f_v;

    logic signed [MN_W-1:0]  r_g_mn_x, r_g_mn_y, r_g_mn_z;
    t_tail                   r_g_tail;
    logic                    r_g_v;

    t_out_item               r_result;
    logic                    r_out_v;

    // the whole back pipeline moves only while the output slot frees up
    assign w_adv   = !r_out_v || i_pop;
    assign o_take  = w_adv && i_valid;
    assign o_empty = !r_out_v;
    assign o_result = r_result;

    // outside rays use r = 1/eta, rounded
    assign w_num = (R_W'(1) << (ETA_FRAC + FRAC_W)) + R_W'(i_mid.eta >> 1);

    rrv_div u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_num),
        .i_den (i_mid.eta),
        .o_quo (w_quo)
    );

    assign w_dly_out = r_dly[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_v <= '0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_sq_v  <= '0;
            r_f_v   <= 1'b0;
            r_g_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_dly_v <= {r_dly_v[DIV_STAGES-2:0], i_valid};
            r_a_v   <= r_dly_v[DIV_STAGES-1];
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            r_d_v   <= r_c_v;
            r_sq_v  <= {r_sq_v[SQ_STAGES-2:0], r_d_v};
            r_f_v   <= r_sq_v[SQ_STAGES-1];
            r_g_v   <= r_f_v;
            r_out_v <= r_g_v;
        end
    end

    always_comb begin
        w_rrh = r_b_rr + RR_W'(HALF);
        w_sh  = CC_W'(ONE2) - r_b_cc + CC_W'(HALF);
        w_rch = r_b_rcp + RCP_W'(HALF);

        w_c_tail    = r_b_tail;
        w_c_tail.rc = w_rch[RCP_W-1:FRAC_W];

        w_tir = r_d_prod > PROD_W'(ONE2);
        w_k   = w_tir ? '0 : K_W'(PROD_W'(ONE2) - r_d_prod);
        w_sq_in     = r_d_tail;
        w_sq_in.tir = w_tir;
    end

    rrv_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (SQ_IN_W'(w_k)),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dly[0] <= i_mid;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_dly[i] <= r_dly[i-1];
            end

            // select the ratio
            r_a_r   <= w_dly_out.outside ? w_quo :
                       R_W'(w_dly_out.eta) << (FRAC_W - ETA_FRAC);
            r_a_mid <= w_dly_out;

            r_b_rr         <= RR_W'(r_a_r) * RR_W'(r_a_r);
            r_b_rcp        <= RCP_W'(r_a_r) * RCP_W'(r_a_mid.cos_c);
            r_b_cc         <= CC_W'(r_a_mid.cos_c) * CC_W'(r_a_mid.cos_c);
            r_b_tail.pix_x <= $signed({1'b0, r_a_r}) * r_a_mid.inc_x;
            r_b_tail.pix_y <= $signed({1'b0, r_a_r}) * r_a_mid.inc_y;
            r_b_tail.pix_z <= $signed({1'b0, r_a_r}) * r_a_mid.inc_z;
            r_b_tail.nrm_x <= r_a_mid.nrm_x;
            r_b_tail.nrm_y <= r_a_mid.nrm_y;
            r_b_tail.nrm_z <= r_a_mid.nrm_z;
            r_b_tail.rc    <= '0;
            r_b_tail.tir   <= 1'b0;

            r_c_q    <= w_rrh[RR_W-1:FRAC_W];
            r_c_s    <= w_sh[FRAC_W+S_W-1:FRAC_W];
            r_c_tail <= w_c_tail;

            r_d_prod <= PROD_W'(r_c_q) * PROD_W'(r_c_s);
            r_d_tail <= r_c_tail;

            r_sq[0] <= w_sq_in;
            for (int i = 1; i < SQ_STAGES; i++) begin
                r_sq[i] <= r_sq[i-1];
            end

            r_f_m    <= $signed({1'b0, r_sq[SQ_STAGES-1].rc}) - $signed(M_W'(w_root));
            r_f_tail <= r_sq[SQ_STAGES-1];

            r_g_mn_x <= r_f_m * r_f_tail.nrm_x;
            r_g_mn_y <= r_f_m * r_f_tail.nrm_y;
            r_g_mn_z <= r_f_m * r_f_tail.nrm_z;
            r_g_tail <= r_f_tail;

            // total internal reflection: drop the vector, raise the flag
            if (r_g_tail.tir) begin
                r_result.out_x <= '0;
                r_result.out_y <= '0;
                r_result.out_z <= '0;
            end else begin
                r_result.out_x <= f_round_sat(r_g_tail.pix_x, r_g_mn_x);
                r_result.out_y <= f_round_sat(r_g_tail.pix_y, r_g_mn_y);
                r_result.out_z <= f_round_sat(r_g_tail.pix_z, r_g_mn_z);
            end
            r_result.total_reflect <= r_g_tail.tir;
        end
    end

    a_tir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_result.total_reflect |->
            r_result.out_x == '0 && r_result.out_y == '0 && r_result.out_z == '0)
        else $error("reflected result carries a nonzero vector");

    a_quo_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v && r_a_mid.outside |-> r_a_r != '0)
        else $error("reciprocal of eta came out zero");

    a_s_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_v |-> r_c_s <= S_W'(ONE))
        else $error("1 - c^2 above one");

    a_out_leaves_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_v) |-> $past(i_pop))
        else $error("result dropped without a pop");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_pop |=> $stable(r_g_v) && $stable(r_sq_v) && $stable(r_dly_v))
        else $error("back pipeline moved while output blocked");

endmodule

@@ design/ray_refraction_vector.sv @@
// channel   | ports                          | handshake
// ----------+--------------------------------+------------------------------
// request   | i_item (t_in_item)             | push, full  (push && !full)
// result    | o_result (t_out_item)          | empty, pop  (pop && !empty)
//
// One request per cycle sustained while results are popped, one result per request,
// in order. Path: 3 front stages, 1 queue, 9 divider stages (1/eta),
// 4 arithmetic stages, 5 square-root stages, 2 stages and the output register.
// Reset is synchronous, active low; it empties the pipelines and the queue.
// A held result stalls only the back; the front keeps filling the 4-entry queue.
`timescale 1ns / 1ps

module ray_refraction_vector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rrv_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output rrv_pkg::t_out_item o_result
);
    import rrv_pkg::*;

    logic      w_f_valid, w_q_full, w_q_valid, w_take;
    t_mid_item w_f_mid, w_q_mid;

    rrv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .o_valid  (w_f_valid),
        .o_mid    (w_f_mid),
        .i_q_full (w_q_full)
    );

    rrv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_mid),
        .o_full  (w_q_full),
        .i_pop   (w_take),
        .o_valid (w_q_valid),
        .o_data  (w_q_mid)
    );

    rrv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_mid    (w_q_mid),
        .o_take   (w_take),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule
